>>> rtl/core/bstk_pkg.sv
// Package for the bounded sorted top-k store with duplicate suppression.
// Holds the item, result and cell interface types and the status codes.
// Depends on nothing.
package bstk_pkg;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned PosBits    = 5;
  localparam int unsigned CountBits  = 6;
  localparam int unsigned CapBits    = 6;

  localparam logic [StatusBits-1:0] StInserted = 2'd0;
  localparam logic [StatusBits-1:0] StFullWorse = 2'd1;
  localparam logic [StatusBits-1:0] StDupBetter = 2'd2;
  localparam logic [StatusBits-1:0] StPastCap  = 2'd3;

  typedef struct packed {
    logic [ValueBits-1:0] item_fitness;
    logic [KeyBits-1:0]   item_key;
  } item_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [PosBits-1:0]    insert_position;
    logic                  replaced_duplicate;
    logic                  evicted_tail;
    logic [CountBits-1:0]  entry_count;
    logic [ValueBits-1:0]  best_value;
    logic [ValueBits-1:0]  worst_value;
  } result_t;

  typedef enum logic [1:0] {
    OpHold,
    OpPurge,
    OpPack,
    OpInsert
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     evict;
  } cell_ctrl_t;

  // What one cell shows its neighbours.
  typedef struct packed {
    logic                 valid;
    logic                 le;
    logic [ValueBits-1:0] fitness;
    logic [KeyBits-1:0]   key;
  } cell_data_t;

endpackage

>>> rtl/core/bstk_cell.sv
// One cell of the sorted chain: holds a single entry and its valid flag.
// Depends on bstk_pkg for the cell interface and item types.
module bstk_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bstk_pkg::cell_ctrl_t ctrl_i,
  input  bstk_pkg::item_t     item_i,
  input  bstk_pkg::cell_data_t left_i,
  input  bstk_pkg::cell_data_t right_i,
  output bstk_pkg::cell_data_t data_o,
  output logic                match_o
);
  import bstk_pkg::*;

  logic                 valid_q, valid_d;
  logic [ValueBits-1:0] fit_q, fit_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic                 le;

  assign le      = valid_q & (fit_q <= item_i.item_fitness);
  assign match_o = valid_q & (key_q == item_i.item_key);

  assign data_o.valid   = valid_q;
  assign data_o.le      = le;
  assign data_o.fitness = fit_q;
  assign data_o.key     = key_q;

  always_comb begin
    valid_d = valid_q;
    fit_d   = fit_q;
    key_d   = key_q;
    unique case (ctrl_i.op)
      OpHold: begin
      end
      OpPurge: begin
        if (match_o) begin
          valid_d = 1'b0;
        end
      end
      OpPack: begin
        // A hole takes its live right neighbour; a live cell behind a hole empties.
        if (!valid_q && right_i.valid) begin
          valid_d = 1'b1;
          fit_d   = right_i.fitness;
          key_d   = right_i.key;
        end else if (valid_q && !left_i.valid) begin
          valid_d = 1'b0;
        end
      end
      OpInsert: begin
        if (left_i.le && !le) begin
          valid_d = 1'b1;
          fit_d   = item_i.item_fitness;
          key_d   = item_i.item_key;
        end else if (!left_i.le) begin
          // The cell just past the old tail drops the entry on eviction.
          valid_d = left_i.valid & ~(ctrl_i.evict & ~valid_q);
          fit_d   = left_i.fitness;
          key_d   = left_i.key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fit_q <= fit_d;
    key_q <= key_d;
  end

endmodule

>>> rtl/core/bounded_sorted_topk_with_dedup.sv
// Bounded sorted top-k store with duplicate suppression, built as a chain of cells.
// A result strobe follows each accepted item: a reject at the first check goes straight to the
// output phase, else the pack phase runs until the removed duplicates have bubbled to the tail.
// A new item is taken only while busy is low; busy is low in the strobe cycle.
// Reset: all cells empty, capacity 32; the receiver cannot stall a result.
// Depends on bstk_pkg and bstk_cell.
module bounded_sorted_topk_with_dedup #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  bstk_pkg::item_t                   item_i,
  output logic                              done_o,
  output bstk_pkg::result_t                 result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bstk_pkg::CapBits-1:0]      cfg_data_i
);
  import bstk_pkg::*;

  // Count width covers the full depth; comparisons run at the wider of that
  // and the register width so that the capacity clamp works at any depth.
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > CountBits) ? CntW : CountBits;

  // Sequencer states. The check looks at the stored list against the held
  // item, the pack phase closes the holes left by removed duplicates, the
  // insert phase shifts the tail right by one cell, and the output phase
  // samples count, best and worst from the updated chain.
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SCheck  = 3'd1;
  localparam logic [2:0] SPack   = 3'd2;
  localparam logic [2:0] SInsert = 3'd3;
  localparam logic [2:0] SOut    = 3'd4;

  logic [2:0]            state_q, state_d;
  item_t                 item_q;
  logic [CapBits-1:0]    cap_q;
  logic [StatusBits-1:0] status_q, status_d;
  logic [PosBits-1:0]    pos_q, pos_d;
  logic                  repl_q, repl_d;
  logic                  evict_q, evict_d;
  logic                  done_q;
  result_t               result_q, result_d;
  cell_ctrl_t            ctrl;

  cell_data_t            cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_v, le_v, match_v, last_v;
  cell_data_t            head_data, tail_data;

  logic [CmpW-1:0]       cap_ext, cap_eff, count_ext, pos_ext;
  logic [ValueBits-1:0]  worst_fit;
  logic                  pack_busy, rej_full, rej_dup;

  // Number of leading ones of a vector that is a run of ones from bit zero.
  function automatic logic [CntW-1:0] thermo_count(input logic [MAX_ENTRIES-1:0] v);
    logic [CntW-1:0] res;
    logic            nxt;
    res = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      nxt = (i == MAX_ENTRIES - 1) ? 1'b0 : v[(i + 1) % MAX_ENTRIES];
      if (v[i] && !nxt) begin
        res = res | CntW'(i + 1);
      end
    end
    return res;
  endfunction

  // The head of the chain looks like a live entry that is never worse than
  // the item, and the far end like an empty cell.
  assign head_data = '{valid: 1'b1, le: 1'b1, fitness: '0, key: '0};
  assign tail_data = '{valid: 1'b0, le: 1'b0, fitness: '0, key: '0};

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    bstk_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .item_i  (item_q),
      .left_i  ((g == 0) ? head_data : cell_data[(g + MAX_ENTRIES - 1) % MAX_ENTRIES]),
      .right_i ((g == MAX_ENTRIES - 1) ? tail_data : cell_data[(g + 1) % MAX_ENTRIES]),
      .data_o  (cell_data[g]),
      .match_o (match_v[g])
    );
    assign valid_v[g] = cell_data[g].valid;
    assign le_v[g]    = cell_data[g].le;
  end

  // The last live cell is the one whose right neighbour is empty.
  assign last_v = valid_v & ~{1'b0, valid_v[MAX_ENTRIES-1:1]};

  // A hole followed by a live entry means the pack phase is not finished.
  assign pack_busy = |(~valid_v[MAX_ENTRIES-2:0] & valid_v[MAX_ENTRIES-1:1]);

  always_comb begin
    worst_fit = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      worst_fit = worst_fit | (last_v[i] ? cell_data[i].fitness : '0);
    end
  end

  // A stored capacity of zero behaves as one and anything above the depth
  // behaves as the depth.
  assign cap_ext = CmpW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(MAX_ENTRIES)) begin
      cap_eff = CmpW'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // The list is sorted, so the cells no worse than the item form a prefix;
  // its length is the insert position. Duplicates that are removed are all
  // worse than the item and lie beyond that prefix, so it does not move.
  assign count_ext = CmpW'(thermo_count(valid_v));
  assign pos_ext   = CmpW'(thermo_count(le_v));

  // A full store turns away an item strictly worse than its current tail.
  assign rej_full = (count_ext >= cap_eff) && (count_ext != '0) &&
                    (item_q.item_fitness > worst_fit);
  assign rej_dup  = |(match_v & le_v);

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    pos_d      = pos_q;
    repl_d     = repl_q;
    evict_d    = evict_q;
    result_d   = result_q;
    ctrl.op    = OpHold;
    ctrl.evict = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        status_d = StInserted;
        pos_d    = '0;
        repl_d   = 1'b0;
        evict_d  = 1'b0;
        if (rej_full) begin
          status_d = StFullWorse;
          state_d  = SOut;
        end else if (rej_dup) begin
          status_d = StDupBetter;
          state_d  = SOut;
        end else begin
          ctrl.op = OpPurge;
          repl_d  = |match_v;
          state_d = SPack;
        end
      end
      SPack: begin
        ctrl.op = OpPack;
        if (!pack_busy) begin
          state_d = SInsert;
        end
      end
      SInsert: begin
        if (pos_ext >= cap_eff) begin
          // The removal of duplicates stands even though the item is not kept.
          status_d = StPastCap;
        end else begin
          ctrl.op    = OpInsert;
          ctrl.evict = (count_ext >= cap_eff);
          evict_d    = (count_ext >= cap_eff);
          pos_d      = pos_ext[PosBits-1:0];
        end
        state_d = SOut;
      end
      SOut: begin
        result_d.status             = status_q;
        result_d.insert_position    = pos_q;
        result_d.replaced_duplicate = repl_q;
        result_d.evicted_tail       = evict_q;
        result_d.entry_count        = count_ext[CountBits-1:0];
        result_d.best_value         = valid_v[0] ? cell_data[0].fitness : '1;
        result_d.worst_value        = (count_ext != '0) ? worst_fit : '1;
        state_d                     = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
      cap_q   <= CapBits'(32);
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SOut);
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start) begin
      item_q <= item_i;
    end
    status_q <= status_d;
    pos_q    <= pos_d;
    repl_q   <= repl_d;
    evict_q  <= evict_d;
    result_q <= result_d;
  end

  assign busy        = (state_q != SIdle);
  assign done_o      = done_q;
  assign result_o    = result_q;
  assign cfg_ready_o = 1'b1;

endmodule

>>> dv/bounded_sorted_topk_with_dedup_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded sorted top-k store with duplicate suppression.
// Drives insert items and capacity writes, predicts every result and compares it.
// Depends on bstk_pkg and the bounded_sorted_topk_with_dedup RTL.
module bounded_sorted_topk_with_dedup_test;
  import bstk_pkg::*;

  localparam int unsigned MaxEntries    = 32;
  // Cycles without any handshake or result before the run is declared hung. The slowest
  // honest step is a long sender gap plus the bubbling of removed duplicates.
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned NumPhases     = 9;
  localparam int unsigned PhaseItems    = 100;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cmd_start = 1'b0;
  logic    cmd_busy;
  item_t   cmd_item = '0;
  logic    res_done;
  result_t res_data;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CapBits-1:0] cfg_data = '0;

  // Items waiting to be offered, and the predicted results still to come back.
  item_t   pend_q[$];
  result_t rank_q[$];

  // Predicted store contents: one spare slot holds the entry pushed past the tail.
  logic [ValueBits-1:0] fit_tab [0:MaxEntries];
  logic [KeyBits-1:0]   key_tab [0:MaxEntries];
  int unsigned          held_cnt = 0;
  int unsigned          cap_setting = 32;

  int unsigned taken_cnt = 0;
  int unsigned popped_cnt = 0;
  int unsigned send_idle_pct = 18;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cap_writes = 0;
  int unsigned status_seen [0:3] = '{0, 0, 0, 0};
  int unsigned phase_cap [0:NumPhases-1];

  bounded_sorted_topk_with_dedup #(
    .MAX_ENTRIES(MaxEntries)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (cmd_start),
    .busy       (cmd_busy),
    .item_i     (cmd_item),
    .done_o     (res_done),
    .result_o   (res_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One line per problem; the count decides the verdict.
  task automatic log_error(input string msg);
    errors++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_error($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                          results_seen, name, got, want));
    end
  endtask

  // Effective capacity: zero behaves as one, anything above the store size as the
  // store size.
  function automatic int unsigned usable_capacity(input int unsigned raw);
    if (raw == 0) begin
      return 1;
    end
    return (raw > MaxEntries) ? MaxEntries : raw;
  endfunction

  // Applies one insert to the predicted store and returns the result it should give.
  function automatic result_t rank_insert(input item_t it);
    result_t     r;
    int unsigned lim;
    int unsigned i;
    int unsigned p;
    r   = '0;
    lim = usable_capacity(cap_setting);
    r.status = StInserted;
    // A full store turns away anything worse than its tail; otherwise an existing
    // entry with the same key and an equal or better fitness blocks the insert.
    if (held_cnt >= lim && held_cnt > 0 && it.item_fitness > fit_tab[held_cnt-1]) begin
      r.status = StFullWorse;
    end else begin
      for (i = 0; i < held_cnt; i++) begin
        if (key_tab[i] == it.item_key && fit_tab[i] <= it.item_fitness) begin
          r.status = StDupBetter;
        end
      end
    end
    if (r.status == StInserted) begin
      // Every worse entry with the same key goes, and that removal stands even when
      // the insert itself then lands past the capacity.
      i = 0;
      while (i < held_cnt) begin
        if (key_tab[i] == it.item_key) begin
          for (p = i; p + 1 < held_cnt; p++) begin
            fit_tab[p] = fit_tab[p+1];
            key_tab[p] = key_tab[p+1];
          end
          held_cnt--;
          r.replaced_duplicate = 1'b1;
        end else begin
          i++;
        end
      end
      // The new entry goes after all entries of equal fitness.
      p = 0;
      while (p < held_cnt && fit_tab[p] <= it.item_fitness) begin
        p++;
      end
      if (p >= lim) begin
        r.status = StPastCap;
      end else begin
        for (i = held_cnt; i > p; i--) begin
          fit_tab[i] = fit_tab[i-1];
          key_tab[i] = key_tab[i-1];
        end
        fit_tab[p] = it.item_fitness;
        key_tab[p] = it.item_key;
        held_cnt++;
        // Only one tail entry drops, even when the capacity was lowered below the count.
        if (held_cnt > lim) begin
          held_cnt--;
          r.evicted_tail = 1'b1;
        end
        r.insert_position = PosBits'(p);
      end
    end
    r.entry_count = CountBits'(held_cnt);
    if (held_cnt == 0) begin
      r.best_value  = '1;
      r.worst_value = '1;
    end else begin
      r.best_value  = fit_tab[0];
      r.worst_value = fit_tab[held_cnt-1];
    end
    return r;
  endfunction

  // Driver: offers the oldest pending item at the falling edge and holds it until
  // the block takes it. A fresh item is offered only when the idle draw allows,
  // which scatters gaps over every stage of the block's work.
  always @(negedge clk) begin : driver
    bit offered;
    if (rst_n) begin
      if (taken_cnt != popped_cnt) begin
        void'(pend_q.pop_front());
        popped_cnt++;
        offered = 1'b0;
      end
      if (!offered && pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = 1'b1;
      end
      if (offered) begin
        cmd_item <= pend_q[0];
      end
      cmd_start <= offered;
    end
  end

  // Monitor: everything is sampled at the rising edge. A result strobe is checked
  // before a same-edge acceptance is predicted, since the strobe belongs to an
  // older item.
  always @(posedge clk) begin : monitor
    result_t     want;
    bit          active;
    int unsigned quiet;
    if (rst_n) begin
      active = 1'b0;
      if (res_done) begin
        active = 1'b1;
        results_seen++;
        if (rank_q.size() == 0) begin
          log_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = rank_q.pop_front();
          check_field("status", res_data.status, want.status);
          check_field("insert_position", res_data.insert_position, want.insert_position);
          check_field("replaced_duplicate", res_data.replaced_duplicate,
                      want.replaced_duplicate);
          check_field("evicted_tail", res_data.evicted_tail, want.evicted_tail);
          check_field("entry_count", res_data.entry_count, want.entry_count);
          check_field("best_value", res_data.best_value, want.best_value);
          check_field("worst_value", res_data.worst_value, want.worst_value);
        end
      end
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        cap_setting = 32'(cfg_data);
        cap_writes++;
      end
      if (cmd_start && !cmd_busy) begin
        active = 1'b1;
        want = rank_insert(cmd_item);
        status_seen[want.status]++;
        rank_q = {rank_q, want};
        taken_cnt++;
      end
      quiet = active ? 0 : quiet + 1;
      if (quiet >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic queue_cmd(input logic [ValueBits-1:0] fit, input logic [KeyBits-1:0] key);
    item_t it;
    it.item_fitness = fit;
    it.item_key     = key;
    pend_q = {pend_q, it};
  endtask

  // Returns once every queued item has been taken, every result has come back and
  // the block reports itself idle; only then is the capacity touched.
  task automatic wait_quiet();
    @(posedge clk);
    while (pend_q.size() != 0 || rank_q.size() != 0 || cmd_busy || cmd_start) begin
      @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [CapBits-1:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random insert: mostly small fitness and key ranges so that ties, duplicates and
  // a full store are common, with extremes and full-width values mixed in.
  task automatic queue_random_cmd(input int unsigned fit_span, input int unsigned key_span);
    logic [ValueBits-1:0] fit;
    logic [KeyBits-1:0]   key;
    int unsigned          pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      fit = '0;
    end else if (pick < 10) begin
      fit = '1;
    end else if (pick < 16) begin
      fit = $urandom();
    end else begin
      fit = $urandom_range(fit_span);
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      key = '0;
    end else if (pick < 8) begin
      key = '1;
    end else if (pick < 14) begin
      key = $urandom();
    end else begin
      key = $urandom_range(key_span);
    end
    queue_cmd(fit, key);
  endtask

  initial begin : stimulus
    int unsigned lim;
    phase_cap = '{32, 1, 7, 63, 0, 2, 33, 12, 3};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on a capacity of three: extremes of both fields, a tail
    // eviction, every rejection kind and a worse duplicate being replaced.
    write_capacity(CapBits'(3));
    queue_cmd(32'd100, 32'd1);
    queue_cmd(32'd0, 32'd0);
    queue_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(32'd50, 32'd7);
    queue_cmd(32'd200, 32'd9);
    queue_cmd(32'd100, 32'd9);
    queue_cmd(32'd100, 32'd1);
    queue_cmd(32'd20, 32'd1);
    queue_cmd(32'd0, 32'd0);
    queue_cmd(32'd10, 32'hFFFF_FFFF);
    // Capacity lowered below the count: an accepted insert drops one tail entry only.
    write_capacity(CapBits'(2));
    queue_cmd(32'd5, 32'd3);
    // Still lower: a plain insert past the capacity, then a duplicate removal that
    // stands although the insert itself lands past the capacity.
    write_capacity(CapBits'(1));
    queue_cmd(32'd4, 32'd8);
    queue_cmd(32'd7, 32'hFFFF_FFFF);
    // Out-of-range capacities: zero acts as one, large values as the store size.
    write_capacity(CapBits'(0));
    queue_cmd(32'hFFFF_FFFF, 32'd2);
    write_capacity(CapBits'(63));
    queue_cmd(32'd0, 32'd0);
    queue_cmd(32'hFFFF_FFFF, 32'd2);
    queue_cmd(32'hFFFF_FFFF, 32'd2);
    queue_cmd(32'hFFFF_FFFE, 32'd2);

    // Random phases: the sender idles rarely at first, then often, then never.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      write_capacity(phase_cap[ph][CapBits-1:0]);
      send_idle_pct = (ph < 3) ? 18 : (ph < 6) ? 88 : 0;
      lim = usable_capacity(phase_cap[ph]);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        queue_random_cmd(4 * lim + 8, lim + lim / 2 + 2);
      end
    end

    wait_quiet();
    // Leave room for a late or spurious strobe before judging the run.
    repeat (60) @(posedge clk);
    while (rank_q.size() != 0) begin
      log_error("expected result never arrived");
      void'(rank_q.pop_front());
    end
    $display("Summary: %0d items taken, %0d results checked, %0d capacity writes.",
             taken_cnt, results_seen, cap_writes);
    $display("Outcomes: %0d inserted, %0d full, %0d duplicate, %0d past capacity.",
             status_seen[StInserted], status_seen[StFullWorse],
             status_seen[StDupBetter], status_seen[StPastCap]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> bounded_sorted_topk_with_dedup.f
rtl/core/bstk_pkg.sv
rtl/core/bstk_cell.sv
rtl/core/bounded_sorted_topk_with_dedup.sv
dv/bounded_sorted_topk_with_dedup_test.sv
